// ----- rtl/core/bfa_pkg.sv -----
// Package for the first-fit bitmap allocator: map geometry, operation and
// status codes, controller state type.
// No dependencies.
package bfa_pkg;

	// map geometry
	localparam int ENTRIES   = 1024;
	localparam int WORD_BITS = 32;
	localparam int MAP_WORDS = (ENTRIES + WORD_BITS - 1) / WORD_BITS;
	localparam int WORD_AW   = $clog2(MAP_WORDS);
	localparam int BIT_AW    = $clog2(WORD_BITS);

	// field widths
	localparam int IDX_W = 10;
	localparam int CNT_W = 11;

	// largest usable limit: capacity, bounded by the index span
	localparam int INDEX_SPAN = 1 << IDX_W;
	localparam int LIMIT_CAP  = (ENTRIES < INDEX_SPAN) ? ENTRIES : INDEX_SPAN;

	// operation codes
	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_TEST    = 2'd2,
		OP_MARK    = 2'd3
	} op_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	// controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_RMW,
		S_HOLD
	} state_t;

endpackage

// ----- rtl/core/bfa_ifs.sv -----
// Channel interfaces of the bitmap allocator: request, response and
// configuration write. Depends on bfa_pkg.
interface bfa_req_if import bfa_pkg::*; ();
	logic             valid;
	logic             ready;
	op_t              operation;
	logic [IDX_W-1:0] entry_index;

	modport source (output valid, operation, entry_index, input ready);
	modport sink   (input valid, operation, entry_index, output ready);
endinterface

interface bfa_rsp_if import bfa_pkg::*; ();
	logic             valid;
	logic             ready;
	status_t          status;
	logic [IDX_W-1:0] result_index;
	logic             was_used;
	logic [CNT_W-1:0] used_count;

	modport source (output valid, status, result_index, was_used, used_count, input ready);
	modport sink   (input valid, status, result_index, was_used, used_count, output ready);
endinterface

interface bfa_cfg_if import bfa_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/core/bitmap_first_free_allocator_top.sv -----
// First-fit bitmap allocator: usage map in a word-wide synchronous memory,
// scan and read-modify-write controller, used-entry count.
// Depends on bfa_pkg and the interfaces in bfa_ifs.
//
// One item is in work at a time. The usage map sits in a memory of 32 words
// of 32 bits, read one word per cycle through a registered read port. An
// allocate scans the words in order up to the first one with a free usable
// entry, at most ceil(limit / 32) words; release, test and mark read the
// indexed word, and release and mark write it back when they change the bit;
// an out-of-range index or an allocate with a limit of zero needs no memory
// access. The next item is accepted in the cycle after the result enters the
// output register; a result that waits in the output register holds the
// following result back until it is taken. The output register lets the
// next item be accepted while a result still waits. The map is clear straight
// out of reset (per-word valid flags, no clearing pass). The limit register
// may be written whenever the block is idle and holds 1024 after reset.
module bitmap_first_free_allocator_top
	import bfa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	bfa_cfg_if.sink    cfg,
	bfa_req_if.sink    req,
	bfa_rsp_if.source  rsp
);

	// usage map memory and per-word valid flags
	logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
	logic [MAP_WORDS-1:0] word_vld_q;
	logic [WORD_BITS-1:0] rd_data_q;
	logic                 rd_vld_q;

	// controller state and latched item
	state_t           state_q, state_nxt;
	op_t              op_q;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] limit_q;
	logic [WORD_AW-1:0] ptr_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] usable_q;

	// pending result
	status_t          pend_status_q;
	logic [IDX_W-1:0] pend_idx_q;
	logic             pend_was_q;
	logic [CNT_W-1:0] pend_count_q;

	// output register
	logic             ovld_q;
	status_t          out_status_q;
	logic [IDX_W-1:0] out_idx_q;
	logic             out_was_q;
	logic [CNT_W-1:0] out_count_q;

	// datapath
	logic [CNT_W-1:0]     limit_now;
	logic                 req_fire;
	logic                 slot_free;
	logic [WORD_AW-1:0]   rd_addr;
	logic [WORD_BITS-1:0] rd_word;
	logic [WORD_BITS-1:0] lim_mask;
	logic [WORD_BITS-1:0] free_bits;
	logic                 any_free;
	logic [BIT_AW-1:0]    ff_bit;
	logic                 last_word;
	logic [WORD_BITS-1:0] bit_sel;
	logic                 cur_bit;
	logic                 wr_en;
	logic [WORD_AW-1:0]   wr_addr;
	logic [WORD_BITS-1:0] flip_mask;
	logic                 cnt_inc;
	logic                 cnt_dec;
	logic [CNT_W-1:0]     count_nxt;

	// handshakes
	assign cfg.ready  = 1'b1;
	assign req.ready  = (state_q == S_IDLE);
	assign req_fire   = req.valid && (state_q == S_IDLE);
	assign slot_free  = !ovld_q || rsp.ready;
	assign limit_now  = (usable_q > CNT_W'(LIMIT_CAP)) ? CNT_W'(LIMIT_CAP) : usable_q;

	// limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			usable_q <= CNT_W'(LIMIT_CAP);
		end else if (cfg.valid) begin
			usable_q <= cfg.data;
		end
	end

	// read address: first word or indexed word on accept, next word while scanning
	always_comb begin
		if (state_q == S_SCAN) begin
			rd_addr = ptr_q + WORD_AW'(1);
		end else if (req.operation == OP_ALLOC) begin
			rd_addr = '0;
		end else begin
			rd_addr = req.entry_index[BIT_AW +: WORD_AW];
		end
	end

	// memory read and write
	always_ff @(posedge clk) begin
		rd_data_q <= map_mem[rd_addr];
		if (wr_en) begin
			map_mem[wr_addr] <= rd_word ^ flip_mask;
		end
	end

	// word valid flags: an unwritten word reads as clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_vld_q <= '0;
			rd_vld_q   <= 1'b0;
		end else begin
			rd_vld_q <= word_vld_q[rd_addr];
			if (wr_en) begin
				word_vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	assign rd_word = rd_vld_q ? rd_data_q : '0;

	// usable bits of the scanned word and first free bit
	always_comb begin
		for (int b = 0; b < WORD_BITS; b++) begin
			lim_mask[b] = CNT_W'({ptr_q, BIT_AW'(b)}) < limit_q;
		end
		free_bits = ~rd_word & lim_mask;
		any_free  = |free_bits;
		ff_bit    = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (free_bits[i]) begin
				ff_bit = BIT_AW'(i);
			end
		end
	end

	assign last_word = limit_q <= (CNT_W'({ptr_q, BIT_AW'(0)}) + CNT_W'(WORD_BITS));

	// indexed bit of the read word
	assign bit_sel = WORD_BITS'(1) << idx_q[BIT_AW-1:0];
	assign cur_bit = |(rd_word & bit_sel);

	// write-back and count update
	always_comb begin
		wr_en     = 1'b0;
		wr_addr   = idx_q[BIT_AW +: WORD_AW];
		flip_mask = bit_sel;
		cnt_inc   = 1'b0;
		cnt_dec   = 1'b0;
		if (state_q == S_SCAN) begin
			wr_addr   = ptr_q;
			flip_mask = WORD_BITS'(1) << ff_bit;
			wr_en     = any_free;
			cnt_inc   = any_free;
		end else if (state_q == S_RMW) begin
			if (op_q == OP_RELEASE && cur_bit) begin
				wr_en   = 1'b1;
				cnt_dec = count_q != '0;
			end else if (op_q == OP_MARK && !cur_bit) begin
				wr_en   = 1'b1;
				cnt_inc = 1'b1;
			end
		end
	end

	always_comb begin
		count_nxt = count_q;
		if (cnt_inc) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (cnt_dec) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					if (req.operation == OP_ALLOC) begin
						state_nxt = (limit_now == '0) ? S_HOLD : S_SCAN;
					end else if (CNT_W'(req.entry_index) >= limit_now) begin
						state_nxt = S_HOLD;
					end else begin
						state_nxt = S_RMW;
					end
				end
			end
			S_SCAN: begin
				if (any_free || last_word) begin
					state_nxt = S_HOLD;
				end
			end
			S_RMW: begin
				state_nxt = S_HOLD;
			end
			S_HOLD: begin
				if (slot_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ptr_q   <= '0;
		end else begin
			state_q <= state_nxt;
			count_q <= count_nxt;
			if (req_fire) begin
				ptr_q <= '0;
			end else if (state_q == S_SCAN) begin
				ptr_q <= ptr_q + WORD_AW'(1);
			end
		end
	end

	// latched item and pending result
	always_ff @(posedge clk) begin
		if (req_fire) begin
			op_q       <= req.operation;
			idx_q      <= req.entry_index;
			limit_q    <= limit_now;
			pend_idx_q <= (req.operation == OP_ALLOC) ? '0 : req.entry_index;
			pend_was_q <= 1'b0;
			pend_count_q <= count_q;
			pend_status_q <= (req.operation == OP_ALLOC) ? ST_FULL : ST_RANGE;
		end else if (state_q == S_SCAN) begin
			pend_count_q <= count_nxt;
			if (any_free) begin
				pend_status_q <= ST_OK;
				pend_idx_q    <= {ptr_q, ff_bit};
			end
		end else if (state_q == S_RMW) begin
			pend_status_q <= ST_OK;
			pend_was_q    <= cur_bit;
			pend_count_q  <= count_nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (state_q == S_HOLD && slot_free) begin
			ovld_q <= 1'b1;
		end else if (rsp.ready) begin
			ovld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_HOLD && slot_free) begin
			out_status_q <= pend_status_q;
			out_idx_q    <= pend_idx_q;
			out_was_q    <= pend_was_q;
			out_count_q  <= pend_count_q;
		end
	end

	assign rsp.valid        = ovld_q;
	assign rsp.status       = out_status_q;
	assign rsp.result_index = out_idx_q;
	assign rsp.was_used     = out_was_q;
	assign rsp.used_count   = out_count_q;

endmodule

// ----- rtl/core/bfa_chk.sv -----
// Port-level checker for the bitmap allocator, with its bind to the top level.
// Depends on bfa_pkg.
module bfa_chk
	import bfa_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input status_t          rsp_status,
	input logic [IDX_W-1:0] rsp_result_index,
	input logic             rsp_was_used,
	input logic [CNT_W-1:0] rsp_used_count
);

	// a full allocate reports index zero and a clear previous bit
	a_full_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_FULL |-> rsp_result_index == '0 && !rsp_was_used)
		else $error("full result with nonzero index or set bit");

	// an out-of-range item never reports a set bit
	a_range_was: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_RANGE |-> !rsp_was_used)
		else $error("out-of-range result reports a set bit");

	// count never exceeds capacity
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_used_count <= CNT_W'(LIMIT_CAP))
		else $error("used count above capacity");

	// a stalled item holds its status, index and count
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_result_index) && $stable(rsp_used_count))
		else $error("response item changed while stalled");

endmodule

bind bitmap_first_free_allocator_top bfa_chk u_bfa_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_status       (rsp.status),
	.rsp_result_index (rsp.result_index),
	.rsp_was_used     (rsp.was_used),
	.rsp_used_count   (rsp.used_count)
);
